### rtl/assert_macros.svh
// Assertion helpers shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

### rtl/wavp_pkg.sv
package wavp_pkg;

   typedef enum logic [2:0] {
      PH_RIFF = 3'd0,
      PH_CHDR = 3'd1,
      PH_FMT  = 3'd2,
      PH_SKIP = 3'd3,
      PH_PAD  = 3'd4,
      PH_DATA = 3'd5,
      PH_IDLE = 3'd6
   } phase_type;

   localparam logic [1:0] KIND_FRAME  = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [1:0] ERR_NOT_RIFF = 2'd0;
   localparam logic [1:0] ERR_CHUNK    = 2'd1;
   localparam logic [1:0] ERR_FORMAT   = 2'd2;

   localparam logic [31:0] TAG_FMT    = 32'h666D7420;
   localparam logic [31:0] TAG_DATA   = 32'h64617461;
   localparam logic [31:0] FMT_BYTES  = 32'd16;
   localparam logic [15:0] PCM_FORMAT = 16'd1;
   localparam logic [15:0] MONO       = 16'd1;
   localparam logic [15:0] STEREO     = 16'd2;

   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] left_sample;
      logic signed [15:0] right_sample;
      logic [31:0]        rate_hz;
      logic [1:0]         channel_count;
      logic [30:0]        frame_total;
      logic [1:0]         error_code;
      logic               last_frame;
   } rsp_type;

   // expected RIFF/WAVE header byte; positions 4..7 are the size, not checked
   function automatic logic riff_byte_ok(input logic [3:0] idx, input logic [7:0] b);
      logic ok;
      ok = 1'b1;
      case (idx)
         4'd0: ok = (b == 8'h52);
         4'd1: ok = (b == 8'h49);
         4'd2: ok = (b == 8'h46);
         4'd3: ok = (b == 8'h46);
         4'd8: ok = (b == 8'h57);
         4'd9: ok = (b == 8'h41);
         4'd10: ok = (b == 8'h56);
         4'd11: ok = (b == 8'h45);
         default: ok = 1'b1;
      endcase
      return ok;
   endfunction

endpackage

### rtl/wavp_parse.sv
// Front part: header and chunk walker. Takes one byte a cycle while byte_valid is
// high, produces at most one result a cycle into the queue.
module wavp_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               byte_valid,
   input  wavp_pkg::req_type  byte_item,
   output logic               rsp_push,
   output wavp_pkg::rsp_type  rsp_item
);

   wavp_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] len_ff, len_in;
   logic [15:0] fmt_tag_ff, fmt_tag_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] align_ff, align_in;
   logic [15:0] bits_ff, bits_in;
   logic        fmt_found_ff, fmt_found_in;
   logic [30:0] frames_ff, frames_in;
   logic [23:0] fbytes_ff, fbytes_in;
   logic [1:0]  fidx_ff, fidx_in;
   logic        pad_ff, pad_in;

   wavp_pkg::phase_type ph;
   logic [7:0]  b;
   logic [31:0] len_new;
   logic [31:0] tag_new;
   logic [30:0] frames_dec;
   logic [1:0]  last_idx;
   logic        produced;
   logic [15:0] lsamp, rsamp;

   always_comb begin
      ph           = byte_item.start_of_file ? wavp_pkg::PH_RIFF : phase_ff;
      b            = byte_item.data_byte;
      phase_in     = phase_ff;
      count_in     = byte_item.start_of_file ? 4'd0 : count_ff;
      tag_in       = byte_item.start_of_file ? 32'd0 : tag_ff;
      len_in       = byte_item.start_of_file ? 32'd0 : len_ff;
      fmt_tag_in   = byte_item.start_of_file ? 16'd0 : fmt_tag_ff;
      chan_in      = byte_item.start_of_file ? 16'd0 : chan_ff;
      rate_in      = byte_item.start_of_file ? 32'd0 : rate_ff;
      align_in     = byte_item.start_of_file ? 16'd0 : align_ff;
      bits_in      = byte_item.start_of_file ? 16'd0 : bits_ff;
      fmt_found_in = byte_item.start_of_file ? 1'b0 : fmt_found_ff;
      frames_in    = byte_item.start_of_file ? 31'd0 : frames_ff;
      fbytes_in    = byte_item.start_of_file ? 24'd0 : fbytes_ff;
      fidx_in      = byte_item.start_of_file ? 2'd0 : fidx_ff;
      pad_in       = byte_item.start_of_file ? 1'b0 : pad_ff;
      produced     = 1'b0;
      rsp_item     = '0;
      len_new      = '0;
      tag_new      = '0;
      frames_dec   = frames_in - 31'd1;
      last_idx     = (chan_in == wavp_pkg::STEREO) ? 2'd3 : 2'd1;
      lsamp        = '0;
      rsamp        = '0;

      case (ph)
         wavp_pkg::PH_RIFF: begin
            if (!wavp_pkg::riff_byte_ok(count_in, b)) begin
               produced            = 1'b1;
               rsp_item.kind       = wavp_pkg::KIND_ERROR;
               rsp_item.error_code = wavp_pkg::ERR_NOT_RIFF;
               phase_in            = wavp_pkg::PH_IDLE;
            end else if (count_in == 4'd11) begin
               count_in = 4'd0;
               phase_in = wavp_pkg::PH_CHDR;
            end else begin
               count_in = count_in + 4'd1;
               phase_in = wavp_pkg::PH_RIFF;
            end
         end
         wavp_pkg::PH_CHDR: begin
            tag_new = tag_in;
            len_new = len_in;
            case (count_in[2:0])
               3'd0, 3'd1, 3'd2, 3'd3: tag_new = {tag_in[23:0], b};
               3'd4: len_new = {24'd0, b};
               3'd5: len_new = {len_in[31:16], b, len_in[7:0]};
               3'd6: len_new = {len_in[31:24], b, len_in[15:0]};
               default: len_new = {b, len_in[23:0]};
            endcase
            tag_in = tag_new;
            len_in = len_new;
            if (count_in != 4'd7) begin
               count_in = count_in + 4'd1;
            end else begin
               count_in = 4'd0;
               if (tag_new == wavp_pkg::TAG_FMT) begin
                  if (len_new < wavp_pkg::FMT_BYTES) begin
                     produced            = 1'b1;
                     rsp_item.kind       = wavp_pkg::KIND_ERROR;
                     rsp_item.error_code = wavp_pkg::ERR_FORMAT;
                     phase_in            = wavp_pkg::PH_IDLE;
                  end else begin
                     len_in   = len_new - wavp_pkg::FMT_BYTES;
                     phase_in = wavp_pkg::PH_FMT;
                  end
               end else if (tag_new == wavp_pkg::TAG_DATA) begin
                  produced = 1'b1;
                  phase_in = wavp_pkg::PH_IDLE;
                  rsp_item.kind = wavp_pkg::KIND_ERROR;
                  if (!fmt_found_in || fmt_tag_in != wavp_pkg::PCM_FORMAT ||
                      (chan_in != wavp_pkg::MONO && chan_in != wavp_pkg::STEREO) ||
                      bits_in != wavp_pkg::FMT_BYTES[15:0]) begin
                     rsp_item.error_code = wavp_pkg::ERR_CHUNK;
                  end else if (align_in != {chan_in[14:0], 1'b0}) begin
                     rsp_item.error_code = wavp_pkg::ERR_FORMAT;
                  end else begin
                     frames_in = (chan_in == wavp_pkg::STEREO) ? {1'b0, len_new[31:2]}
                                                               : len_new[31:1];
                     rsp_item.kind          = wavp_pkg::KIND_HEADER;
                     rsp_item.rate_hz       = rate_in;
                     rsp_item.channel_count = chan_in[1:0];
                     rsp_item.frame_total   = frames_in;
                     fidx_in   = 2'd0;
                     fbytes_in = 24'd0;
                     phase_in  = (frames_in == 31'd0) ? wavp_pkg::PH_IDLE
                                                      : wavp_pkg::PH_DATA;
                  end
               end else begin
                  pad_in = len_new[0];
                  if (len_new != 32'd0)     phase_in = wavp_pkg::PH_SKIP;
                  else if (len_new[0])      phase_in = wavp_pkg::PH_PAD;
                  else                      phase_in = wavp_pkg::PH_CHDR;
               end
            end
         end
         wavp_pkg::PH_FMT: begin
            case (count_in)
               4'd0: fmt_tag_in = {8'd0, b};
               4'd1: fmt_tag_in = {b, fmt_tag_in[7:0]};
               4'd2: chan_in = {8'd0, b};
               4'd3: chan_in = {b, chan_in[7:0]};
               4'd4: rate_in = {24'd0, b};
               4'd5: rate_in = {rate_in[31:16], b, rate_in[7:0]};
               4'd6: rate_in = {rate_in[31:24], b, rate_in[15:0]};
               4'd7: rate_in = {b, rate_in[23:0]};
               4'd12: align_in = {8'd0, b};
               4'd13: align_in = {b, align_in[7:0]};
               4'd14: bits_in = {8'd0, b};
               4'd15: bits_in = {b, bits_in[7:0]};
               default: ;
            endcase
            if (count_in == 4'd15) begin
               fmt_found_in = 1'b1;
               count_in     = 4'd0;
               pad_in       = len_in[0];
               if (len_in != 32'd0) phase_in = wavp_pkg::PH_SKIP;
               else if (len_in[0])  phase_in = wavp_pkg::PH_PAD;
               else                 phase_in = wavp_pkg::PH_CHDR;
            end else begin
               count_in = count_in + 4'd1;
               phase_in = wavp_pkg::PH_FMT;
            end
         end
         wavp_pkg::PH_SKIP: begin
            len_in = len_in - 32'd1;
            if (len_in != 32'd0)  phase_in = wavp_pkg::PH_SKIP;
            else if (pad_in)      phase_in = wavp_pkg::PH_PAD;
            else begin
               phase_in = wavp_pkg::PH_CHDR;
               count_in = 4'd0;
            end
         end
         wavp_pkg::PH_PAD: begin
            phase_in = wavp_pkg::PH_CHDR;
            count_in = 4'd0;
         end
         wavp_pkg::PH_DATA: begin
            phase_in = wavp_pkg::PH_DATA;
            if (fidx_in < last_idx) begin
               case (fidx_in)
                  2'd0: fbytes_in = {fbytes_in[23:8], b};
                  2'd1: fbytes_in = {fbytes_in[23:16], b, fbytes_in[7:0]};
                  default: fbytes_in = {b, fbytes_in[15:0]};
               endcase
               fidx_in = fidx_in + 2'd1;
            end else begin
               if (last_idx == 2'd1) begin
                  lsamp = {b, fbytes_in[7:0]};
                  rsamp = lsamp;
               end else begin
                  lsamp = fbytes_in[15:0];
                  rsamp = {b, fbytes_in[23:16]};
               end
               fbytes_in = 24'd0;
               fidx_in   = 2'd0;
               frames_in = frames_dec;
               produced  = 1'b1;
               rsp_item.kind         = wavp_pkg::KIND_FRAME;
               rsp_item.left_sample  = lsamp;
               rsp_item.right_sample = rsamp;
               rsp_item.last_frame   = (frames_dec == 31'd0);
               if (frames_dec == 31'd0) phase_in = wavp_pkg::PH_IDLE;
            end
         end
         default: phase_in = wavp_pkg::PH_IDLE;
      endcase

      // end of file: error if no result yet and still inside the header
      if (byte_item.end_of_file) begin
         if (!produced && phase_in != wavp_pkg::PH_DATA &&
             phase_in != wavp_pkg::PH_IDLE) begin
            produced            = 1'b1;
            rsp_item            = '0;
            rsp_item.kind       = wavp_pkg::KIND_ERROR;
            rsp_item.error_code = (phase_in == wavp_pkg::PH_RIFF) ? wavp_pkg::ERR_NOT_RIFF :
                                  (phase_in == wavp_pkg::PH_FMT)  ? wavp_pkg::ERR_FORMAT :
                                                                    wavp_pkg::ERR_CHUNK;
         end
         phase_in = wavp_pkg::PH_IDLE;
      end
      rsp_push = byte_valid && produced;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= wavp_pkg::PH_RIFF;
         count_ff     <= '0;
         tag_ff       <= '0;
         len_ff       <= '0;
         fmt_tag_ff   <= '0;
         chan_ff      <= '0;
         rate_ff      <= '0;
         align_ff     <= '0;
         bits_ff      <= '0;
         fmt_found_ff <= 1'b0;
         frames_ff    <= '0;
         fbytes_ff    <= '0;
         fidx_ff      <= '0;
         pad_ff       <= 1'b0;
      end else if (byte_valid) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         tag_ff       <= tag_in;
         len_ff       <= len_in;
         fmt_tag_ff   <= fmt_tag_in;
         chan_ff      <= chan_in;
         rate_ff      <= rate_in;
         align_ff     <= align_in;
         bits_ff      <= bits_in;
         fmt_found_ff <= fmt_found_in;
         frames_ff    <= frames_in;
         fbytes_ff    <= fbytes_in;
         fidx_ff      <= fidx_in;
         pad_ff       <= pad_in;
      end
   end

endmodule

### rtl/wavp_queue.sv
// Small result queue between the parser and the output register
`include "assert_macros.svh"
module wavp_queue #(
   parameter int unsigned DEPTH = wavp_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wavp_pkg::rsp_type push_item,
   output logic              full,
   output logic              not_empty,
   input  logic              pop,
   output wavp_pkg::rsp_type pop_item
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   wavp_pkg::rsp_type slot_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   assign full      = (cnt_ff == (AW+1)'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_item  = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_item;
   end

   `ASSERT_IMPL(a_no_overflow, clock, reset, push, !full || pop, "queue overflow")
   `ASSERT_IMPL(a_no_underflow, clock, reset, pop, not_empty, "queue underflow")
   `ASSERT_NEXT(a_count_grows, clock, reset, push && !pop, cnt_ff != '0, "count lost push")

endmodule

### rtl/wav_pcm16_stream_parser.sv
// Channel | Direction | Payload              | Handshake
// req     | in        | req_type (byte+flags)| req_valid / req_stall
// rsp     | out       | rsp_type (result)    | rsp_valid / rsp_stall
// One byte per cycle is taken while req_stall is low; each byte is parsed in the cycle it is accepted.
// A result passes the queue, then the output register, before it shows on rsp_valid.
// The queue holds QUEUE_DEPTH results; req_stall rises when it is full.
// Reset is synchronous and returns the parser to the RIFF header phase.
`include "assert_macros.svh"
module wav_pcm16_stream_parser #(
   parameter int unsigned QUEUE_DEPTH = wavp_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wavp_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wavp_pkg::rsp_type rsp_item
);

   logic              acc;
   logic              push;
   wavp_pkg::rsp_type push_item;
   logic              q_full, q_ne, q_pop;
   wavp_pkg::rsp_type q_item;
   logic              out_valid_ff, out_valid_in;
   wavp_pkg::rsp_type out_item_ff;

   assign req_stall = q_full;
   assign acc       = req_valid && !req_stall;

   wavp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (acc),
      .byte_item  (req_item),
      .rsp_push   (push),
      .rsp_item   (push_item)
   );

   wavp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .not_empty (q_ne),
      .pop       (q_pop),
      .pop_item  (q_item)
   );

   // output register reloads when empty or taken
   assign q_pop        = q_ne && (!out_valid_ff || !rsp_stall);
   assign out_valid_in = q_pop || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (q_pop) out_item_ff <= q_item;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   `ASSERT_IMPL(a_stall_when_full, clock, reset, q_full, req_stall, "full queue not stalling")
   `ASSERT_NEXT(a_hold_out, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped")
   `ASSERT_NEXT(a_hold_item, clock, reset, rsp_valid && rsp_stall, $stable(rsp_item), "stalled result changed")

endmodule

### test/wav_pcm16_stream_parser_tb.sv
module wav_pcm16_stream_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   wavp_pkg::req_type req_item = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   wavp_pkg::rsp_type rsp_item;

   wav_pcm16_stream_parser u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
   );

   always #4 clock = ~clock;

   // parser state mirror
   wavp_pkg::phase_type ph;
   logic [31:0] cnt, tag, clen, rate;
   logic [15:0] fmt_tag, chans, align, bits;
   logic        fmt_seen;
   logic [30:0] left_frames;
   logic [23:0] fbytes;
   logic [1:0]  fidx;

   wavp_pkg::req_type byte_q[$];
   wavp_pkg::rsp_type result_q[$];
   int      errors = 0;
   logic    stim_done = 1'b0;
   longint  cycles = 0;

   function automatic logic [7:0] riff_byte(input int i);
      case (i)
         0: return 8'h52; 1: return 8'h49; 2: return 8'h46; 3: return 8'h46;
         8: return 8'h57; 9: return 8'h41; 10: return 8'h56; 11: return 8'h45;
         default: return 8'h00;
      endcase
   endfunction

   task automatic parser_clear();
      ph = wavp_pkg::PH_RIFF; cnt = '0; tag = '0; clen = '0; fmt_tag = '0; chans = '0;
      rate = '0; align = '0; bits = '0; fmt_seen = 1'b0; left_frames = '0;
      fbytes = '0; fidx = '0;
   endtask

   task automatic next_after_payload();
      if (clen != 0) ph = wavp_pkg::PH_SKIP;
      else if (cnt[0]) ph = wavp_pkg::PH_PAD;
      else begin
         ph = wavp_pkg::PH_CHDR;
         cnt = '0;
      end
   endtask

   task automatic raise_error(inout wavp_pkg::rsp_type r, inout bit got,
                              input logic [1:0] code);
      r = '0;
      r.kind = wavp_pkg::KIND_ERROR;
      r.error_code = code;
      got = 1'b1;
      ph = wavp_pkg::PH_IDLE;
   endtask

   // advance the mirror by one byte; queue any result it produces
   task automatic parse_byte(input wavp_pkg::req_type it);
      wavp_pkg::rsp_type r;
      bit          got;
      logic [7:0]  b;
      logic [31:0] i;
      logic [15:0] l, rr;
      r = '0; got = 1'b0; b = it.data_byte;
      if (it.start_of_file) parser_clear();
      i = cnt;
      case (ph)
         wavp_pkg::PH_RIFF: begin
            if ((i < 4 || i >= 8) && i < 12 && b != riff_byte(i))
               raise_error(r, got, wavp_pkg::ERR_NOT_RIFF);
            else begin
               cnt = i + 32'd1;
               if (cnt >= 12) begin
                  cnt = '0;
                  ph = wavp_pkg::PH_CHDR;
               end
            end
         end
         wavp_pkg::PH_CHDR: begin
            if (i < 4) tag = {tag[23:0], b};
            else if (i == 4) clen = {24'd0, b};
            else clen = clen | ({24'd0, b} << (8 * ((i - 4) & 3)));
            cnt = i + 32'd1;
            if (cnt >= 8) begin
               cnt = '0;
               if (tag == wavp_pkg::TAG_FMT) begin
                  if (clen < wavp_pkg::FMT_BYTES) raise_error(r, got, wavp_pkg::ERR_FORMAT);
                  else begin
                     clen = clen - wavp_pkg::FMT_BYTES;
                     ph = wavp_pkg::PH_FMT;
                  end
               end else if (tag == wavp_pkg::TAG_DATA) begin
                  if (!fmt_seen || fmt_tag != wavp_pkg::PCM_FORMAT ||
                      (chans != wavp_pkg::MONO && chans != wavp_pkg::STEREO) ||
                      bits != 16'd16)
                     raise_error(r, got, wavp_pkg::ERR_CHUNK);
                  else if (align != 16'(chans * 2) || align == 0)
                     raise_error(r, got, wavp_pkg::ERR_FORMAT);
                  else begin
                     left_frames = 31'(clen >> ((chans == wavp_pkg::STEREO) ? 2 : 1));
                     r.kind = wavp_pkg::KIND_HEADER;
                     r.rate_hz = rate;
                     r.channel_count = chans[1:0];
                     r.frame_total = left_frames;
                     got = 1'b1;
                     fidx = '0; fbytes = '0;
                     ph = (left_frames == 0) ? wavp_pkg::PH_IDLE : wavp_pkg::PH_DATA;
                  end
               end else begin
                  cnt = {31'd0, clen[0]};
                  next_after_payload();
               end
            end
         end
         wavp_pkg::PH_FMT: begin
            case (i)
               0: fmt_tag[7:0] = b;  1: fmt_tag[15:8] = b;
               2: chans[7:0] = b;    3: chans[15:8] = b;
               4: rate[7:0] = b;     5: rate[15:8] = b;
               6: rate[23:16] = b;   7: rate[31:24] = b;
               12: align[7:0] = b;   13: align[15:8] = b;
               14: bits[7:0] = b;    15: bits[15:8] = b;
               default: ;
            endcase
            cnt = i + 32'd1;
            if (cnt >= wavp_pkg::FMT_BYTES) begin
               fmt_seen = 1'b1;
               cnt = {31'd0, clen[0]};
               next_after_payload();
            end
         end
         wavp_pkg::PH_SKIP: begin
            clen = clen - 32'd1;
            if (clen == 0) next_after_payload();
         end
         wavp_pkg::PH_PAD: begin
            ph = wavp_pkg::PH_CHDR;
            cnt = '0;
         end
         wavp_pkg::PH_DATA: begin
            if (fidx < ((chans == wavp_pkg::STEREO) ? 3 : 1)) begin
               fbytes = fbytes | (24'(b) << (8 * fidx));
               fidx = fidx + 2'd1;
            end else begin
               if (chans != wavp_pkg::STEREO) begin
                  l = {b, fbytes[7:0]};
                  rr = l;
               end else begin
                  l = fbytes[15:0];
                  rr = {b, fbytes[23:16]};
               end
               fbytes = '0; fidx = '0;
               left_frames = left_frames - 31'd1;
               r.kind = wavp_pkg::KIND_FRAME;
               r.left_sample = l;
               r.right_sample = rr;
               r.last_frame = (left_frames == 0);
               got = 1'b1;
               if (left_frames == 0) ph = wavp_pkg::PH_IDLE;
            end
         end
         default: ;
      endcase
      // early end of file
      if (it.end_of_file) begin
         if (!got && ph != wavp_pkg::PH_DATA && ph != wavp_pkg::PH_IDLE)
            raise_error(r, got, (ph == wavp_pkg::PH_RIFF) ? wavp_pkg::ERR_NOT_RIFF :
                        (ph == wavp_pkg::PH_FMT) ? wavp_pkg::ERR_FORMAT :
                                                   wavp_pkg::ERR_CHUNK);
         ph = wavp_pkg::PH_IDLE;
      end
      if (got) result_q.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input wavp_pkg::rsp_type got,
                                  input wavp_pkg::rsp_type exp);
      errors++;
      $display("mismatch %s: got %h expected %h", what, got, exp);
   endtask

   // ---- stimulus builders ----
   task automatic put(input logic [7:0] b, input bit sof = 1'b0, input bit eof = 1'b0);
      wavp_pkg::req_type it;
      it.data_byte = b; it.start_of_file = sof; it.end_of_file = eof;
      byte_q.push_back(it);
   endtask

   task automatic put32(input logic [31:0] v);
      for (int k = 0; k < 4; k++) put(v[8*k +: 8]);
   endtask

   task automatic put_tag(input logic [31:0] t);
      for (int k = 3; k >= 0; k--) put(t[8*k +: 8]);
   endtask

   task automatic riff_head();
      put(8'h52, 1'b1);
      for (int k = 1; k < 12; k++)
         put((k >= 4 && k < 8) ? 8'($urandom) : riff_byte(k));
   endtask

   task automatic fmt_chunk(input logic [15:0] ftag, input logic [15:0] ch,
                            input logic [15:0] al, input logic [15:0] bt,
                            input logic [31:0] extra);
      put_tag(wavp_pkg::TAG_FMT);
      put32(32'd16 + extra);
      put(ftag[7:0]); put(ftag[15:8]); put(ch[7:0]); put(ch[15:8]);
      put32($urandom); put32($urandom);
      put(al[7:0]); put(al[15:8]); put(bt[7:0]); put(bt[15:8]);
      for (int k = 0; k < extra + extra[0]; k++) put(8'($urandom));
   endtask

   // well-formed file with random content, optional truncation
   task automatic good_file(input int chn, input int nframes, input bit cut);
      int nb;
      riff_head();
      if ($urandom_range(0, 2) == 0) begin
         int n;
         n = $urandom_range(0, 5);
         put_tag($urandom); put32(32'(n));
         for (int k = 0; k < n + n % 2; k++) put(8'($urandom));
      end
      fmt_chunk(wavp_pkg::PCM_FORMAT, 16'(chn), 16'(chn * 2), 16'd16,
                $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 32'd0);
      put_tag(wavp_pkg::TAG_DATA);
      put32(32'(nframes * chn * 2) + $urandom_range(0, chn * 2 - 1));
      nb = nframes * chn * 2;
      if (cut && nb > 0) nb = $urandom_range(0, nb - 1);
      for (int k = 0; k < nb; k++) put(8'($urandom), 1'b0, (k == nb - 1) && cut);
   endtask

   task automatic noise_file(input int n);
      put(8'($urandom), 1'b1);
      for (int k = 1; k < n; k++)
         put(($urandom_range(0, 3) == 0) ? riff_byte(k % 12) : 8'($urandom), 1'b0,
             $urandom_range(0, 30) == 0);
   endtask

   initial begin
      int pick;
      // directed: extremes of samples in mono, then a stereo frame of -1 and 0
      riff_head(); fmt_chunk(wavp_pkg::PCM_FORMAT, wavp_pkg::MONO, 16'd2, 16'd16, 32'd0);
      put_tag(wavp_pkg::TAG_DATA); put32(32'd4);
      put(8'h00); put(8'h80); put(8'hFF); put(8'h7F);
      riff_head(); fmt_chunk(wavp_pkg::PCM_FORMAT, wavp_pkg::STEREO, 16'd4, 16'd16, 32'd0);
      put_tag(wavp_pkg::TAG_DATA); put32(32'd4);
      put(8'hFF); put(8'hFF); put(8'h00); put(8'h00);
      // bad magic, short fmt, missing fmt, bad format/channels/bits/alignment
      put(8'h00, 1'b1);
      riff_head(); put_tag(wavp_pkg::TAG_FMT); put32(32'd15);
      riff_head(); put_tag(wavp_pkg::TAG_DATA); put32(32'd0);
      riff_head(); fmt_chunk(16'd3, wavp_pkg::MONO, 16'd2, 16'd16, 32'd0);
      put_tag(wavp_pkg::TAG_DATA); put32(32'd8);
      riff_head(); fmt_chunk(wavp_pkg::PCM_FORMAT, 16'd3, 16'd6, 16'd16, 32'd0);
      put_tag(wavp_pkg::TAG_DATA); put32(32'd8);
      riff_head(); fmt_chunk(wavp_pkg::PCM_FORMAT, wavp_pkg::MONO, 16'd2, 16'd8, 32'd0);
      put_tag(wavp_pkg::TAG_DATA); put32(32'd8);
      riff_head(); fmt_chunk(wavp_pkg::PCM_FORMAT, wavp_pkg::STEREO, 16'd2, 16'd16, 32'd0);
      put_tag(wavp_pkg::TAG_DATA); put32(32'd8);
      // later fmt overrides; zero frames; huge size
      riff_head(); fmt_chunk(16'd7, wavp_pkg::MONO, 16'd2, 16'd16, 32'd0);
      fmt_chunk(wavp_pkg::PCM_FORMAT, wavp_pkg::MONO, 16'd2, 16'd16, 32'd0);
      put_tag(wavp_pkg::TAG_DATA); put32(32'd1);
      riff_head(); fmt_chunk(wavp_pkg::PCM_FORMAT, wavp_pkg::STEREO, 16'd4, 16'd16, 32'd0);
      put_tag(wavp_pkg::TAG_DATA); put32(32'hFFFF_FFFF); put(8'hAA, 1'b0, 1'b1);
      // early end in each phase
      put(8'h52, 1'b1, 1'b1);
      riff_head(); put(8'h66, 1'b0, 1'b1);
      riff_head(); put_tag(wavp_pkg::TAG_FMT); put32(32'd20); put(8'h01, 1'b0, 1'b1);
      riff_head(); put_tag(32'h4C495354); put32(32'd3); put(8'h00, 1'b0, 1'b1);
      riff_head(); put_tag(32'h4C495354); put32(32'd1); put(8'h00);
      put(8'h00, 1'b0, 1'b1);
      good_file(2, 3, 1'b1);
      // random part
      while (byte_q.size() < 1050) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) good_file($urandom_range(1, 2), $urandom_range(0, 12), 1'b0);
         else if (pick < 8) good_file($urandom_range(1, 2), $urandom_range(1, 8), 1'b1);
         else noise_file($urandom_range(3, 30));
      end
   end

   // reset
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: random gaps, mostly short
   int gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) parse_byte(req_item);
         if (req_valid && req_stall) begin
         end else if (gap > 0) begin
            gap--;
            req_valid <= 1'b0;
         end else if (byte_q.size() > 0) begin
            req_item <= byte_q.pop_front();
            req_valid <= 1'b1;
            if ($urandom_range(0, 7) == 0)
               gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
         end else begin
            req_valid <= 1'b0;
            stim_done <= 1'b1;
         end
      end
   end

   // receiver stall pattern, with one long hold-off early on
   int hold = 0;
   always @(posedge clock) begin
      if (cycles == 300) hold = 200;
      if (hold > 0) begin
         hold--;
         rsp_stall <= 1'b1;
      end else if ((cycles / 2000) % 2 == 1) rsp_stall <= 1'b0;
      else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         if ($urandom_range(0, 15) == 0) hold = $urandom_range(10, 40);
      end else rsp_stall <= 1'b0;
   end

   // monitor
   always @(posedge clock) begin
      wavp_pkg::rsp_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (result_q.size() == 0) begin
            report_mismatch("unexpected", rsp_item, '0);
         end else begin
            exp = result_q.pop_front();
            if (rsp_item.kind != exp.kind) report_mismatch("kind", rsp_item, exp);
            if (rsp_item.left_sample != exp.left_sample) report_mismatch("left", rsp_item, exp);
            if (rsp_item.right_sample != exp.right_sample)
               report_mismatch("right", rsp_item, exp);
            if (rsp_item.rate_hz != exp.rate_hz) report_mismatch("rate", rsp_item, exp);
            if (rsp_item.channel_count != exp.channel_count)
               report_mismatch("channels", rsp_item, exp);
            if (rsp_item.frame_total != exp.frame_total)
               report_mismatch("frames", rsp_item, exp);
            if (rsp_item.error_code != exp.error_code) report_mismatch("code", rsp_item, exp);
            if (rsp_item.last_frame != exp.last_frame) report_mismatch("last", rsp_item, exp);
         end
      end
   end

   // end of run
   int drain = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("wav_pcm16_stream_parser_tb NOT OK");
         $finish;
      end else if (stim_done && result_q.size() == 0) begin
         drain++;
         if (drain == 20) begin
            if (errors == 0) $display("wav_pcm16_stream_parser_tb OK");
            else $display("wav_pcm16_stream_parser_tb NOT OK");
            $finish;
         end
      end
   end

endmodule
